/* rtl/core/vas_pkg.sv */
package vas_pkg;

  // Default width of the autorotation second counter
  localparam int unsigned ROTATION_BITS_DEF = 25;

  // Item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_OPEN  = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;
  localparam logic [1:0] FUNC_MODE  = 2'd3;

  // Work mode codes
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_NORMAL    = 2'd1;
  localparam logic [1:0] MODE_UNIVERSAL = 2'd2;

  // Alarm state codes
  localparam logic [1:0] ALARM_ACTIVE  = 2'd1;
  localparam logic [1:0] ALARM_CLEARED = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORK_DRIVE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXERCISE_DRIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP            = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL       = 3'd4;

  localparam int unsigned CFG_DATA_W = 24;

  // Configuration reset values
  localparam logic [7:0]  WORK_DRIVE_RST     = 8'd120;
  localparam logic [7:0]  EXERCISE_DRIVE_RST = 8'd25;
  localparam logic [7:0]  GAP_RST            = 8'd1;
  localparam logic [7:0]  SETTLE_RST         = 8'd1;
  localparam logic [23:0] INTERVAL_RST       = 24'd1209600;

  // Width of interval + exercise drive + two gaps
  localparam int unsigned REOPEN_W = 26;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] new_mode;
    logic [1:0] alarm_state;
  } vas_in_t;

  typedef struct packed {
    logic power_relay;
    logic control_relay;
    logic is_opening;
    logic is_opened;
    logic is_closing;
    logic is_closed;
    logic move_allowed;
    logic exercising;
  } vas_out_t;

  typedef struct packed {
    logic opening;
    logic opened;
    logic closing;
    logic closed;
  } vas_pos_t;

endpackage

/* rtl/core/valve_actuator_sequencer.sv */
// Channel  | Direction | Handshake               | Word
// in_      | in        | in_valid / in_stall     | vas_in_t: func, new_mode, alarm_state
// out_     | out       | out_valid / out_stall   | vas_out_t: relays, position, status
// cfg_     | in        | cfg_valid / cfg_ready   | cfg_index (3 bit), cfg_data (24 bit)
//
// One word is taken per cycle; its result appears in the output register on the
// next cycle. Each word is handled in a single pass of logic from the state
// registers to the state and result registers.
// Input is stalled only while a held result is itself stalled.
// Synchronous active-low reset clears all state but the output data register and loads configuration defaults.
module valve_actuator_sequencer
  import vas_pkg::*;
#(
  parameter int unsigned ROTATION_BITS = ROTATION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vas_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vas_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CMP_W = (ROTATION_BITS > REOPEN_W) ? ROTATION_BITS + 1 : REOPEN_W + 1;

  // Configuration
  logic [7:0]  work_drive_r, exercise_drive_r, gap_r, settle_r;
  logic [23:0] interval_r;

  // Sequencer state
  logic [1:0]               mode_r, mode_nxt;
  vas_pos_t                 pos_r, pos_nxt;
  logic                     pwr_r, pwr_nxt;
  logic                     ctl_r, ctl_nxt;
  logic [7:0]               power_tmr_r, power_tmr_nxt;
  logic [9:0]               control_tmr_r, control_tmr_nxt;
  logic [7:0]               gap_tmr_r, gap_tmr_nxt;
  logic [7:0]               settle_tmr_r, settle_tmr_nxt;
  logic                     move_ok_r, move_ok_nxt;
  logic [ROTATION_BITS-1:0] rot_r, rot_nxt;
  logic                     exercise_r, exercise_nxt;

  // Output register
  logic     out_valid_r, out_valid_nxt;
  vas_out_t out_data_r, out_data_nxt;

  logic                in_accept;
  logic                alarm_act, alarm_clr, do_close, ex_enabled;
  logic [REOPEN_W-1:0] reopen_at;
  logic [CMP_W-1:0]    rot_ext, reopen_ext, interval_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign alarm_act = (in_data.alarm_state == ALARM_ACTIVE);
  assign alarm_clr = (in_data.alarm_state == ALARM_CLEARED);
  assign do_close  = alarm_act | (in_data.func == FUNC_CLOSE);

  assign reopen_at = REOPEN_W'(interval_r) + REOPEN_W'(exercise_drive_r)
                   + REOPEN_W'({gap_r, 1'b0});
  assign reopen_ext   = CMP_W'(reopen_at);
  assign interval_ext = CMP_W'(interval_r);

  always_comb begin
    mode_nxt        = mode_r;
    pos_nxt         = pos_r;
    pwr_nxt         = pwr_r;
    ctl_nxt         = ctl_r;
    power_tmr_nxt   = power_tmr_r;
    control_tmr_nxt = control_tmr_r;
    gap_tmr_nxt     = gap_tmr_r;
    settle_tmr_nxt  = settle_tmr_r;
    move_ok_nxt     = move_ok_r;
    rot_nxt         = rot_r;
    exercise_nxt    = exercise_r;
    ex_enabled      = 1'b0;
    rot_ext         = '0;

    // Tick: settle wait, rotation count, move timers
    if (in_data.func == FUNC_TICK) begin
      if (!move_ok_nxt) begin
        if (settle_tmr_nxt != 8'd0) settle_tmr_nxt = settle_tmr_nxt - 8'd1;
        else move_ok_nxt = 1'b1;
      end
      if (mode_nxt == MODE_NORMAL) begin
        if (!pos_nxt.closed && rot_nxt != {ROTATION_BITS{1'b1}}) begin
          rot_nxt = rot_nxt + ROTATION_BITS'(1);
        end
        if (!(pos_nxt.opening && pos_nxt.closing)) begin
          if (pos_nxt.opening && power_tmr_nxt != 8'd0) begin
            power_tmr_nxt = power_tmr_nxt - 8'd1;
            if (power_tmr_nxt == 8'd0) begin
              pwr_nxt      = 1'b0;
              pos_nxt      = '{opened: 1'b1, default: 1'b0};
              exercise_nxt = 1'b0;
            end
          end
          if (pos_nxt.closing) begin
            if (gap_tmr_nxt == 8'd0) begin
              if (power_tmr_nxt != 8'd0) begin
                pwr_nxt       = 1'b1;
                power_tmr_nxt = power_tmr_nxt - 8'd1;
              end else begin
                pwr_nxt = 1'b0;
              end
            end else begin
              gap_tmr_nxt = gap_tmr_nxt - 8'd1;
            end
            if (control_tmr_nxt != 10'd0) begin
              control_tmr_nxt = control_tmr_nxt - 10'd1;
              if (control_tmr_nxt == 10'd0) begin
                ctl_nxt = 1'b0;
                pos_nxt = '{closed: 1'b1, default: 1'b0};
              end
            end
          end
        end
      end
    end

    // Open request
    if (!alarm_act && in_data.func == FUNC_OPEN) begin
      if (pos_nxt.closing) begin
        pwr_nxt        = 1'b0;
        ctl_nxt        = 1'b0;
        pos_nxt        = '{opened: (mode_nxt == MODE_UNIVERSAL), default: 1'b0};
        move_ok_nxt    = 1'b0;
        settle_tmr_nxt = settle_r;
      end else if (mode_nxt == MODE_NORMAL) begin
        if (!pos_nxt.opened && !pos_nxt.opening && move_ok_nxt) begin
          pos_nxt       = '{opening: 1'b1, default: 1'b0};
          pwr_nxt       = 1'b1;
          ctl_nxt       = 1'b0;
          power_tmr_nxt = work_drive_r;
        end
      end else if (mode_nxt == MODE_UNIVERSAL) begin
        if (!pos_nxt.opened && move_ok_nxt) begin
          pos_nxt = '{opened: 1'b1, default: 1'b0};
          pwr_nxt = 1'b0;
          ctl_nxt = 1'b0;
        end
      end
    end

    // Close request, also forced by an active alarm
    if (do_close && (alarm_act || in_data.func != FUNC_TICK)) begin
      if (pos_nxt.opening) begin
        pwr_nxt        = 1'b0;
        ctl_nxt        = 1'b0;
        pos_nxt        = '{opened: (mode_nxt == MODE_UNIVERSAL), default: 1'b0};
        move_ok_nxt    = 1'b0;
        settle_tmr_nxt = settle_r;
      end else if (mode_nxt == MODE_NORMAL) begin
        if (!pos_nxt.closing && !pos_nxt.closed && move_ok_nxt) begin
          pos_nxt         = '{closing: 1'b1, default: 1'b0};
          pwr_nxt         = 1'b0;
          ctl_nxt         = 1'b1;
          control_tmr_nxt = 10'(gap_r) + 10'(work_drive_r) + 10'(gap_r);
          power_tmr_nxt   = work_drive_r;
          gap_tmr_nxt     = gap_r;
          rot_nxt         = '0;
        end
      end else if (mode_nxt == MODE_UNIVERSAL) begin
        if ((!pos_nxt.closed && move_ok_nxt) || alarm_act) begin
          pos_nxt = '{closed: 1'b1, default: 1'b0};
          pwr_nxt = 1'b1;
          ctl_nxt = 1'b0;
        end
      end
    end

    // Mode change: select and stop
    if (!alarm_act && in_data.func == FUNC_MODE &&
        (in_data.new_mode == MODE_NORMAL || in_data.new_mode == MODE_UNIVERSAL) &&
        in_data.new_mode != mode_nxt) begin
      mode_nxt       = in_data.new_mode;
      pwr_nxt        = 1'b0;
      ctl_nxt        = 1'b0;
      pos_nxt        = '{opened: (mode_nxt == MODE_UNIVERSAL), default: 1'b0};
      move_ok_nxt    = 1'b0;
      settle_tmr_nxt = settle_r;
    end

    // Autorotation: reopen after the exercise close, then start a new one
    if (!alarm_act) begin
      ex_enabled = alarm_clr && (mode_nxt == MODE_NORMAL);
      rot_ext    = CMP_W'(rot_nxt);
      if (ex_enabled && rot_ext > reopen_ext && !pos_nxt.opened && !pos_nxt.opening) begin
        if (pos_nxt.closing) begin
          pwr_nxt        = 1'b0;
          ctl_nxt        = 1'b0;
          pos_nxt        = '{default: 1'b0};
          move_ok_nxt    = 1'b0;
          settle_tmr_nxt = settle_r;
        end else if (move_ok_nxt) begin
          pos_nxt       = '{opening: 1'b1, default: 1'b0};
          pwr_nxt       = 1'b1;
          ctl_nxt       = 1'b0;
          power_tmr_nxt = work_drive_r;
        end
        rot_nxt = '0;
      end
      rot_ext = CMP_W'(rot_nxt);
      if (ex_enabled && rot_ext > interval_ext && !pos_nxt.closed && !pos_nxt.closing) begin
        if (move_ok_nxt) begin
          pos_nxt         = '{closing: 1'b1, default: 1'b0};
          pwr_nxt         = 1'b0;
          ctl_nxt         = 1'b1;
          control_tmr_nxt = 10'(gap_r) + 10'(exercise_drive_r) + 10'(gap_r);
          power_tmr_nxt   = exercise_drive_r;
          gap_tmr_nxt     = gap_r;
        end
        exercise_nxt = 1'b1;
      end
    end

    out_data_nxt.power_relay   = pwr_nxt;
    out_data_nxt.control_relay = ctl_nxt;
    out_data_nxt.is_opening    = pos_nxt.opening;
    out_data_nxt.is_opened     = pos_nxt.opened;
    out_data_nxt.is_closing    = pos_nxt.closing;
    out_data_nxt.is_closed     = pos_nxt.closed;
    out_data_nxt.move_allowed  = move_ok_nxt;
    out_data_nxt.exercising    = exercise_nxt;
  end

  // Hold the result until taken; a fresh word replaces it
  always_comb begin
    if (in_accept) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_drive_r     <= WORK_DRIVE_RST;
      exercise_drive_r <= EXERCISE_DRIVE_RST;
      gap_r            <= GAP_RST;
      settle_r         <= SETTLE_RST;
      interval_r       <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WORK_DRIVE:     work_drive_r     <= cfg_data[7:0];
        CFG_EXERCISE_DRIVE: exercise_drive_r <= cfg_data[7:0];
        CFG_GAP:            gap_r            <= cfg_data[7:0];
        CFG_SETTLE:         settle_r         <= cfg_data[7:0];
        CFG_INTERVAL:       interval_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_NONE;
      pos_r         <= '0;
      pwr_r         <= 1'b0;
      ctl_r         <= 1'b0;
      power_tmr_r   <= '0;
      control_tmr_r <= '0;
      gap_tmr_r     <= '0;
      settle_tmr_r  <= '0;
      move_ok_r     <= 1'b0;
      rot_r         <= '0;
      exercise_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        mode_r        <= mode_nxt;
        pos_r         <= pos_nxt;
        pwr_r         <= pwr_nxt;
        ctl_r         <= ctl_nxt;
        power_tmr_r   <= power_tmr_nxt;
        control_tmr_r <= control_tmr_nxt;
        gap_tmr_r     <= gap_tmr_nxt;
        settle_tmr_r  <= settle_tmr_nxt;
        move_ok_r     <= move_ok_nxt;
        rot_r         <= rot_nxt;
        exercise_r    <= exercise_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= out_data_nxt;
  end

  // At most one position flag at a time
  a_pos_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({pos_r.opening, pos_r.opened, pos_r.closing, pos_r.closed}))
    else $error("more than one position flag set");

  // An opening move drives power alone
  a_opening_relays: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r.opening |-> (pwr_r && !ctl_r))
    else $error("opening without power relay alone");

  // A closing move holds the direction relay
  a_closing_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r.closing |-> ctl_r)
    else $error("closing without control relay");

  // Every accepted word yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted word gave no result");

  // Exercise flag only rises with an accepted word
  a_exercise_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(exercise_r) |-> $past(in_accept))
    else $error("exercise flag rose without a word");

endmodule

/* tb/tb_valve_actuator_sequencer.sv */
`timescale 1ns / 100ps

module tb_valve_actuator_sequencer;
  import vas_pkg::*;

  localparam logic [1:0] ALARM_NEVER = 2'd0;
  localparam logic [1:0] ALARM_UNDEF = 2'd3;
  localparam logic [1:0] MODE_BAD    = 2'd3;
  localparam int unsigned ROT_W      = ROTATION_BITS_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 6;

  // Register settings per phase; phase 0 runs on the reset values
  int unsigned work_set[NUM_PHASES]     = '{120, 3, 0, 255, 5, 1};
  int unsigned exdrive_set[NUM_PHASES]  = '{25, 2, 0, 255, 3, 1};
  int unsigned gap_set[NUM_PHASES]      = '{1, 1, 0, 255, 2, 0};
  int unsigned settle_set[NUM_PHASES]   = '{1, 2, 0, 255, 1, 3};
  int unsigned interval_set[NUM_PHASES] = '{1209600, 6, 0, 16777215, 12, 3};
  int unsigned words_set[NUM_PHASES]    = '{150, 350, 300, 150, 350, 350};

  class valve_scoreboard;
    // register copies
    logic [7:0]  work_drive;
    logic [7:0]  ex_drive;
    logic [7:0]  gap_len;
    logic [7:0]  settle_len;
    logic [23:0] interval;
    // valve state
    logic [1:0]       mode;
    vas_pos_t         pos;
    logic             pwr;
    logic             ctl;
    logic [7:0]       pwr_t;
    logic [9:0]       ctl_t;
    logic [7:0]       gap_t;
    logic [7:0]       settle_t;
    logic             move_ok;
    logic [ROT_W-1:0] rot_s;
    logic             ex_flag;

    vas_out_t expected_status[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned exercising_seen;

    function new();
      work_drive = WORK_DRIVE_RST;
      ex_drive   = EXERCISE_DRIVE_RST;
      gap_len    = GAP_RST;
      settle_len = SETTLE_RST;
      interval   = INTERVAL_RST;
      mode       = MODE_NONE;
      pos        = '0;
      pwr        = 1'b0;
      ctl        = 1'b0;
      pwr_t      = '0;
      ctl_t      = '0;
      gap_t      = '0;
      settle_t   = '0;
      move_ok    = 1'b0;
      rot_s      = '0;
      ex_flag    = 1'b0;
      mismatches = 0;
      checked    = 0;
      exercising_seen = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WORK_DRIVE:     work_drive = data[7:0];
        CFG_EXERCISE_DRIVE: ex_drive   = data[7:0];
        CFG_GAP:            gap_len    = data[7:0];
        CFG_SETTLE:         settle_len = data[7:0];
        CFG_INTERVAL:       interval   = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void stop_valve();
      pwr = 1'b0;
      ctl = 1'b0;
      pos = '0;
      if (mode == MODE_UNIVERSAL) pos.opened = 1'b1;
      move_ok  = 1'b0;
      settle_t = settle_len;
    endfunction

    function void start_close(logic [7:0] drive, bit clear_rot);
      if (!pos.closing && !pos.closed && move_ok) begin
        pos = '0;
        pos.closing = 1'b1;
        pwr = 1'b0;
        ctl = 1'b1;
        ctl_t = 10'(gap_len) + 10'(drive) + 10'(gap_len);
        pwr_t = drive;
        gap_t = gap_len;
        if (clear_rot) rot_s = '0;
      end
    endfunction

    function void request_close(bit alarm_act);
      if (pos.opening) begin
        stop_valve();
      end else if (mode == MODE_NORMAL) begin
        start_close(work_drive, 1'b1);
      end else if (mode == MODE_UNIVERSAL) begin
        if ((!pos.closed && move_ok) || alarm_act) begin
          pos = '0;
          pos.closed = 1'b1;
          pwr = 1'b1;
          ctl = 1'b0;
        end
      end
    endfunction

    function void request_open();
      if (pos.closing) begin
        stop_valve();
      end else if (mode == MODE_NORMAL) begin
        if (!pos.opened && !pos.opening && move_ok) begin
          pos = '0;
          pos.opening = 1'b1;
          pwr = 1'b1;
          ctl = 1'b0;
          pwr_t = work_drive;
        end
      end else if (mode == MODE_UNIVERSAL) begin
        if (!pos.opened && move_ok) begin
          pos = '0;
          pos.opened = 1'b1;
          pwr = 1'b0;
          ctl = 1'b0;
        end
      end
    endfunction

    function void run_move_timers();
      if (pos.opening && pwr_t != 0) begin
        pwr_t--;
        if (pwr_t == 0) begin
          pwr = 1'b0;
          pos = '0;
          pos.opened = 1'b1;
          ex_flag = 1'b0;
        end
      end
      if (pos.closing) begin
        // power follows the gap; drop it once the drive time has run out
        if (gap_t == 0) begin
          if (pwr_t != 0) begin
            pwr = 1'b1;
            pwr_t--;
          end else begin
            pwr = 1'b0;
          end
        end else begin
          gap_t--;
        end
        if (ctl_t != 0) begin
          ctl_t--;
          if (ctl_t == 0) begin
            ctl = 1'b0;
            pos = '0;
            pos.closed = 1'b1;
          end
        end
      end
    endfunction

    function void exercise_check(bit cleared);
      longint unsigned reopen_at;
      bit enabled;
      reopen_at = longint'(interval) + longint'(ex_drive) + 2 * longint'(gap_len);
      enabled = cleared && (mode == MODE_NORMAL);
      if (enabled && longint'(rot_s) > reopen_at && !pos.opened && !pos.opening) begin
        request_open();
        rot_s = '0;
      end
      if (enabled && longint'(rot_s) > longint'(interval) && !pos.closed && !pos.closing) begin
        start_close(ex_drive, 1'b0);
        ex_flag = 1'b1;
      end
    endfunction

    function void second_tick();
      if (!move_ok) begin
        if (settle_t != 0) settle_t--;
        else move_ok = 1'b1;
      end
      if (mode == MODE_NORMAL) begin
        if (!pos.closed && rot_s != '1) rot_s++;
        run_move_timers();
      end
    endfunction

    function void note_word(vas_in_t w);
      bit alarm_act;
      vas_out_t res;
      alarm_act = (w.alarm_state == ALARM_ACTIVE);
      if (w.func == FUNC_TICK) begin
        second_tick();
      end else if (!alarm_act) begin
        if (w.func == FUNC_OPEN) begin
          request_open();
        end else if (w.func == FUNC_CLOSE) begin
          request_close(1'b0);
        end else if ((w.new_mode == MODE_NORMAL || w.new_mode == MODE_UNIVERSAL) &&
                     mode != w.new_mode) begin
          mode = w.new_mode;
          stop_valve();
        end
      end
      if (alarm_act) request_close(1'b1);
      else exercise_check(w.alarm_state == ALARM_CLEARED);
      res.power_relay   = pwr;
      res.control_relay = ctl;
      res.is_opening    = pos.opening;
      res.is_opened     = pos.opened;
      res.is_closing    = pos.closing;
      res.is_closed     = pos.closed;
      res.move_allowed  = move_ok;
      res.exercising    = ex_flag;
      expected_status.push_back(res);
    endfunction

    function void check_result(vas_out_t got);
      vas_out_t exp;
      checked++;
      if (got.exercising === 1'b1) exercising_seen++;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %b with nothing outstanding", got);
        return;
      end
      exp = expected_status.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d pwr/ctl/opening/opened/closing/closed/move/ex: expected %b got %b",
                   checked, exp, got);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  vas_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  vas_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  valve_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;

  valve_actuator_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic vas_in_t mk_word(logic [1:0] func, logic [1:0] md, logic [1:0] alarm);
    vas_in_t w;
    w.func = func;
    w.new_mode = md;
    w.alarm_state = alarm;
    return w;
  endfunction

  function automatic logic [1:0] rand_alarm();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ALARM_CLEARED;
    if (r < 75) return ALARM_NEVER;
    if (r < 88) return ALARM_ACTIVE;
    return ALARM_UNDEF;
  endfunction

  function automatic vas_in_t rand_word();
    int r;
    vas_in_t w;
    r = $urandom_range(99);
    w.func = (r < 40) ? FUNC_TICK : (r < 64) ? FUNC_OPEN : (r < 88) ? FUNC_CLOSE : FUNC_MODE;
    r = $urandom_range(99);
    w.new_mode = (r < 55) ? MODE_NORMAL : (r < 80) ? MODE_UNIVERSAL :
                 (r < 90) ? MODE_NONE : MODE_BAD;
    w.alarm_state = rand_alarm();
    return w;
  endfunction

  task automatic push_word(vas_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(int p);
    logic [CFG_DATA_W-1:0] vals[5];
    vals = '{CFG_DATA_W'(work_set[p]), CFG_DATA_W'(exdrive_set[p]), CFG_DATA_W'(gap_set[p]),
             CFG_DATA_W'(settle_set[p]), CFG_DATA_W'(interval_set[p])};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.load_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly tick runs and requests with random content; tick runs let moves finish
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned len;
    logic [1:0] alarm;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 30) begin
        len = $urandom_range(3, 20);
        alarm = ($urandom_range(99) < 70) ? ALARM_CLEARED : ALARM_NEVER;
        repeat (len) push_word(mk_word(FUNC_TICK, 2'($urandom_range(3)), alarm));
        sent += len;
      end else begin
        push_word(rand_word());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 6;
    stall_pct = 55;
    push_word(mk_word(FUNC_OPEN, MODE_NORMAL, ALARM_NEVER));
    push_word(mk_word(FUNC_CLOSE, MODE_NORMAL, ALARM_NEVER));
    push_word(mk_word(FUNC_MODE, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_MODE, MODE_BAD, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_MODE, MODE_NORMAL, ALARM_NEVER));
    push_word(mk_word(FUNC_MODE, MODE_NORMAL, ALARM_CLEARED));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_CLEARED));
    push_word(mk_word(FUNC_OPEN, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_UNDEF));
    // close against an opening: stop
    push_word(mk_word(FUNC_CLOSE, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_CLOSE, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_OPEN, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    // alarm swallows the open and closes instead
    push_word(mk_word(FUNC_OPEN, MODE_NONE, ALARM_ACTIVE));
    push_word(mk_word(FUNC_MODE, MODE_UNIVERSAL, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_TICK, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_CLOSE, MODE_NONE, ALARM_NEVER));
    push_word(mk_word(FUNC_CLOSE, MODE_NONE, ALARM_ACTIVE));
    push_word(mk_word(FUNC_OPEN, MODE_NONE, ALARM_CLEARED));
    push_word(mk_word(FUNC_MODE, MODE_UNIVERSAL, ALARM_ACTIVE));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        write_regs(p);
      end
      if (p < 2) begin
        send_idle_pct = 6;
        stall_pct = 55;
      end else if (p < 4) begin
        send_idle_pct = 55;
        stall_pct = 6;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      run_random(words_set[p] / 2);
      // long receiver hold-off while words keep coming, so the input backs up
      if (p == 1) hold_req = 1'b1;
      // let the pipeline empty completely mid-phase
      if (p == 4) drain_results();
      run_random(words_set[p] - words_set[p] / 2);
    end

    drain_results();
    repeat (3) @(posedge clk);
    $display("Sent %0d words over %0d register settings; %0d results checked,",
             words_sent, NUM_PHASES, sb.checked);
    $display("%0d of them while exercising", sb.exercising_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
